// ----- hdl/tcak_pkg.sv -----
// tcak_pkg: shared constants, codes, types and helpers for the touch
// calibration and key hit block. No dependencies.
`default_nettype none

package tcak_pkg;

  localparam int COORD_W    = 10;
  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 4;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;
  localparam int DEF_KEY_COUNT     = 16;

  localparam int CAL_MARGIN = 10;
  localparam int CAL_OFFSET = 5;

  // scaler widths: span is at most 1014, differences lie in -1023..1023
  localparam int SPAN_W = 10;
  localparam int MAG_W  = 10;
  localparam int DIFF_W = MAG_W + 1;
  localparam int PROD_W = MAG_W + SPAN_W;
  localparam int QUO_W  = PROD_W + 1;
  localparam int CW     = QUO_W + 2;

  localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEN_UP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_FIRST_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_FIRST_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SECOND_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SECOND_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } key_rect_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    key_rect_t         rect;
  } key_load_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } key_req_t;

  typedef struct packed {
    logic             busy;
    logic             hit;
    logic [IDX_W-1:0] index;
  } key_res_t;

  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] num;
    logic [DIFF_W-1:0] den;
  } scale_req_t;

  typedef struct packed {
    logic             busy;
    logic [QUO_W-1:0] quo;
  } scale_res_t;

  // clamp a signed screen coordinate to 0..size-1
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [CW-1:0] v,
                                                     input int size);
    logic signed [CW-1:0] lim;
    lim = CW'(size);
    if (v < 0) begin
      return '0;
    end else if (v >= lim) begin
      return COORD_W'(size - 1);
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tcak_if.sv -----
// tcak_in_if and tcak_out_if: valid/ready channels for the touch block.
// Depends on tcak_pkg for field widths.
`default_nettype none

interface tcak_in_if;
  import tcak_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] raw_x;
  logic [COORD_W-1:0] raw_y;
  logic [SLOT_W-1:0]  key_slot;
  logic [COORD_W-1:0] key_left;
  logic [COORD_W-1:0] key_top;
  logic [COORD_W-1:0] key_width;
  logic [COORD_W-1:0] key_height;

  modport source (output valid, command, raw_x, raw_y, key_slot, key_left, key_top,
                  key_width, key_height, input ready);
  modport sink (input valid, command, raw_x, raw_y, key_slot, key_left, key_top,
                key_width, key_height, output ready);
endinterface

interface tcak_out_if;
  import tcak_pkg::*;
  logic               valid;
  logic               ready;
  logic               pressed;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic               key_hit;
  logic [IDX_W-1:0]   key_index;

  modport source (output valid, pressed, pos_x, pos_y, key_hit, key_index, input ready);
  modport sink (input valid, pressed, pos_x, pos_y, key_hit, key_index, output ready);
endinterface

`default_nettype wire

// ----- hdl/tcak_scale.sv -----
// tcak_scale: sign-magnitude num*SPAN/den, shift-add multiply one span bit
// a cycle then restoring division one quotient bit a cycle. Uses tcak_pkg.
`default_nettype none

module tcak_scale #(
  parameter int SPAN = tcak_pkg::DEF_SCREEN_HEIGHT - tcak_pkg::CAL_MARGIN
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  tcak_pkg::scale_req_t    req,
  output tcak_pkg::scale_res_t    res
);
  import tcak_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [SPAN_W-1:0] mplier_r, mplier_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [MAG_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W-1:0]  dmag_r, dmag_nxt;
  logic              neg_r, neg_nxt;
  logic              zero_r, zero_nxt;

  logic [DIFF_W-1:0] num_abs, den_abs;
  logic [MAG_W:0]    rem_sh;
  logic              q_bit;
  logic signed [QUO_W-1:0] qmag;

  assign num_abs = req.num[DIFF_W-1] ? (~req.num + 1'b1) : req.num;
  assign den_abs = req.den[DIFF_W-1] ? (~req.den + 1'b1) : req.den;
  assign rem_sh  = {rem_r, acc_r[PROD_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, dmag_r});

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    dmag_nxt   = dmag_r;
    neg_nxt    = neg_r;
    zero_nxt   = zero_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          state_nxt  = S_MUL;
          cnt_nxt    = '0;
          mcand_nxt  = PROD_W'(num_abs[MAG_W-1:0]);
          mplier_nxt = SPAN_W'(SPAN);
          acc_nxt    = '0;
          dmag_nxt   = den_abs[MAG_W-1:0];
          neg_nxt    = req.num[DIFF_W-1] ^ req.den[DIFF_W-1];
          zero_nxt   = (req.den == '0);
        end
      end
      S_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[SPAN_W-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SPAN_W - 1)) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
          rem_nxt   = '0;
        end
      end
      S_DIV: begin
        // dividend leaves at the top, quotient bits enter at the bottom
        rem_nxt = q_bit ? MAG_W'(rem_sh - {1'b0, dmag_r}) : rem_sh[MAG_W-1:0];
        acc_nxt = {acc_r[PROD_W-2:0], q_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    dmag_r   <= dmag_nxt;
    neg_r    <= neg_nxt;
    zero_r   <= zero_nxt;
  end

  assign qmag     = {1'b0, acc_r};
  assign res.busy = (state_r != S_IDLE);
  assign res.quo  = zero_r ? '0 : (neg_r ? -qmag : qmag);

endmodule

`default_nettype wire

// ----- hdl/tcak_keys.sv -----
// tcak_keys: key rectangle memory with per-entry valid bits and a scan
// that tests one entry a cycle, lowest index first. Uses tcak_pkg.
`default_nettype none

module tcak_keys #(
  parameter int KEY_COUNT = tcak_pkg::DEF_KEY_COUNT
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  tcak_pkg::key_load_t  load,
  input  tcak_pkg::key_req_t   req,
  output tcak_pkg::key_res_t   res
);
  import tcak_pkg::*;

  localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int SW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(KEY_COUNT - 1);

  key_rect_t          mem [KEY_COUNT];
  key_rect_t          rd_r;
  logic [KEY_COUNT-1:0] valid_r;

  logic               busy_r, issue_r, cmp_v_r, rdv_r, hit_r;
  logic [AW-1:0]      a_r, ridx_r, hidx_r;
  logic [COORD_W-1:0] x_r, y_r;

  logic [SW-1:0]      slot_w, hidx_w;
  logic               in_range;
  logic [AW-1:0]      waddr;
  logic [COORD_W:0]   right, bottom;
  logic               match;

  assign slot_w   = SW'(load.slot);
  assign in_range = (slot_w < SW'(KEY_COUNT));
  assign waddr    = slot_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (load.we && in_range) begin
      mem[waddr] <= load.rect;
    end
    rd_r <= mem[a_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (load.we && in_range) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  assign right  = {1'b0, rd_r.left} + {1'b0, rd_r.width};
  assign bottom = {1'b0, rd_r.top} + {1'b0, rd_r.height};
  assign match  = rdv_r && (x_r >= rd_r.left) && ({1'b0, x_r} <= right) &&
                  (y_r >= rd_r.top) && ({1'b0, y_r} <= bottom);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      cmp_v_r <= 1'b0;
      hit_r   <= 1'b0;
      a_r     <= '0;
    end else if (req.start) begin
      busy_r  <= 1'b1;
      issue_r <= 1'b1;
      cmp_v_r <= 1'b0;
      hit_r   <= 1'b0;
      hidx_r  <= '0;
      a_r     <= '0;
      x_r     <= req.x;
      y_r     <= req.y;
    end else if (busy_r) begin
      if (cmp_v_r && match) begin
        hit_r   <= 1'b1;
        hidx_r  <= ridx_r;
        busy_r  <= 1'b0;
        issue_r <= 1'b0;
        cmp_v_r <= 1'b0;
      end else begin
        // read issue runs one entry ahead of the compare
        if (issue_r) begin
          rdv_r   <= valid_r[a_r];
          ridx_r  <= a_r;
          cmp_v_r <= 1'b1;
          if (a_r == LAST) begin
            issue_r <= 1'b0;
          end else begin
            a_r <= a_r + 1'b1;
          end
        end else begin
          cmp_v_r <= 1'b0;
        end
        if (cmp_v_r && (ridx_r == LAST)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign hidx_w    = SW'(hidx_r);
  assign res.busy  = busy_r;
  assign res.hit   = hit_r;
  assign res.index = hit_r ? hidx_w[IDX_W-1:0] : '0;

endmodule

`default_nettype wire

// ----- hdl/touch_calibrate_and_key_hit.sv -----
// touch_calibrate_and_key_hit: top level. Uses tcak_pkg, tcak_in_if,
// tcak_out_if, tcak_scale (two instances) and tcak_keys.
//
// Usage: commands arrive on in_ch (valid/ready). A pen-down sample is mapped
// through the two-point calibration when calibrated is set, or passed raw,
// then tested against the key rectangles; a pen-up repeats the last position
// with no hit. Each gives one transaction on out_ch. A key load writes the
// rectangle table in the accepting cycle and gives no transaction.
// Registers are written over cfg_we/cfg_index/cfg_data; the user must do so only
// while idle, the block does not enforce it. Path to out_ch.valid: a pen-up goes
// straight to the done state; an uncalibrated pen-down passes the origin check,
// then the key scan unless the point lies left of or above the origin; a
// calibrated pen-down first runs the serial scalers (10 multiply and 20 division
// steps) plus finish and clamp, then the one-entry-a-cycle key scan, which stops
// at the first hit. One item is in work at a time; in_ch.ready is high only when
// idle and rises in the same cycle as out_ch.valid, so the next item may follow.
// A finished transaction sits in the output register while the next item is
// taken; if the receiver still stalls when the following result is ready,
// that result waits in place and in_ch stays not ready.
// Reset clears the registers, last position, key valid bits and both
// channels' control state.
`default_nettype none

module touch_calibrate_and_key_hit #(
  parameter int SCREEN_WIDTH  = tcak_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tcak_pkg::DEF_SCREEN_HEIGHT,
  parameter int KEY_COUNT     = tcak_pkg::DEF_KEY_COUNT
) (
  input  wire                                clk,
  input  wire                                rst_n,
  tcak_in_if.sink                            in_ch,
  tcak_out_if.source                         out_ch,
  input  wire                                cfg_we,
  input  wire [tcak_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [tcak_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcak_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_ORIG = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [COORD_W-1:0] cal_first_x_r, cal_first_y_r, cal_second_x_r, cal_second_y_r;
  logic [COORD_W-1:0] origin_x_r, origin_y_r;
  logic               calibrated_r;

  logic [2:0]         state_r;
  logic [COORD_W-1:0] last_x_r, last_y_r;
  logic               res_pressed_r, res_hit_r;
  logic [IDX_W-1:0]   res_index_r;

  logic               out_valid_r, out_pressed_r, out_hit_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [IDX_W-1:0]   out_index_r;

  logic               accept, out_free;
  scale_req_t         sx_req, sy_req;
  scale_res_t         sx_res, sy_res;
  key_load_t          kload;
  key_req_t           kreq;
  key_res_t           kres;

  logic signed [CW-1:0] tx_s, ty_s;
  logic [COORD_W:0]     dx, dy;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_first_x_r  <= '0;
      cal_first_y_r  <= '0;
      cal_second_x_r <= '0;
      cal_second_y_r <= '0;
      calibrated_r   <= 1'b0;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAL_FIRST_X:  cal_first_x_r  <= cfg_data;
        CFG_CAL_FIRST_Y:  cal_first_y_r  <= cfg_data;
        CFG_CAL_SECOND_X: cal_second_x_r <= cfg_data;
        CFG_CAL_SECOND_Y: cal_second_y_r <= cfg_data;
        CFG_CALIBRATED:   calibrated_r   <= cfg_data[0];
        CFG_ORIGIN_X:     origin_x_r     <= cfg_data;
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // calibration scalers, started at acceptance of a calibrated sample
  assign sy_req.start = accept && (in_ch.command == CMD_PEN_DOWN) && calibrated_r;
  assign sy_req.num   = DIFF_W'({1'b0, in_ch.raw_y}) - DIFF_W'({1'b0, cal_first_y_r});
  assign sy_req.den   = DIFF_W'({1'b0, cal_second_y_r}) - DIFF_W'({1'b0, cal_first_y_r});
  assign sx_req.start = sy_req.start;
  assign sx_req.num   = DIFF_W'({1'b0, in_ch.raw_x}) - DIFF_W'({1'b0, cal_second_x_r});
  assign sx_req.den   = DIFF_W'({1'b0, cal_first_x_r}) - DIFF_W'({1'b0, cal_second_x_r});

  tcak_scale #(.SPAN(SCREEN_WIDTH - CAL_MARGIN)) u_scale_x (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sx_req),
    .res   (sx_res)
  );

  tcak_scale #(.SPAN(SCREEN_HEIGHT - CAL_MARGIN)) u_scale_y (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sy_req),
    .res   (sy_res)
  );

  assign ty_s = $signed(CW'($signed(sy_res.quo))) + $signed(CW'(CAL_OFFSET));
  assign tx_s = $signed(CW'(SCREEN_WIDTH)) - $signed(CW'($signed(sx_res.quo)))
                - $signed(CW'(CAL_OFFSET));

  // point relative to the window origin; top bit set means negative
  assign dx = {1'b0, last_x_r} - {1'b0, origin_x_r};
  assign dy = {1'b0, last_y_r} - {1'b0, origin_y_r};

  assign kload.we          = accept && (in_ch.command == CMD_LOAD);
  assign kload.slot        = in_ch.key_slot;
  assign kload.rect.left   = in_ch.key_left;
  assign kload.rect.top    = in_ch.key_top;
  assign kload.rect.width  = in_ch.key_width;
  assign kload.rect.height = in_ch.key_height;

  assign kreq.start = (state_r == ST_ORIG) && !dx[COORD_W] && !dy[COORD_W];
  assign kreq.x     = dx[COORD_W-1:0];
  assign kreq.y     = dy[COORD_W-1:0];

  tcak_keys #(.KEY_COUNT(KEY_COUNT)) u_keys (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (kload),
    .req   (kreq),
    .res   (kres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a result in ST_DONE refills the output register itself
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.command == CMD_PEN_DOWN) begin
              res_pressed_r <= 1'b1;
              if (calibrated_r) begin
                state_r <= ST_CALC;
              end else begin
                last_x_r <= in_ch.raw_x;
                last_y_r <= in_ch.raw_y;
                state_r  <= ST_ORIG;
              end
            end else if (in_ch.command == CMD_PEN_UP) begin
              res_pressed_r <= 1'b0;
              res_hit_r     <= 1'b0;
              res_index_r   <= '0;
              state_r       <= ST_DONE;
            end
          end
        end
        ST_CALC: begin
          if (!sx_res.busy && !sy_res.busy) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          last_x_r <= clamp_coord(tx_s, SCREEN_WIDTH);
          last_y_r <= clamp_coord(ty_s, SCREEN_HEIGHT);
          state_r  <= ST_ORIG;
        end
        ST_ORIG: begin
          if (kreq.start) begin
            state_r <= ST_SCAN;
          end else begin
            res_hit_r   <= 1'b0;
            res_index_r <= '0;
            state_r     <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (!kres.busy) begin
            res_hit_r   <= kres.hit;
            res_index_r <= kres.index;
            state_r     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_pressed_r <= res_pressed_r;
            out_x_r       <= last_x_r;
            out_y_r       <= last_y_r;
            out_hit_r     <= res_hit_r;
            out_index_r   <= res_index_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pressed   = out_pressed_r;
  assign out_ch.pos_x     = out_x_r;
  assign out_ch.pos_y     = out_y_r;
  assign out_ch.key_hit   = out_hit_r;
  assign out_ch.key_index = out_index_r;

endmodule

`default_nettype wire

// ----- tb/sv/tb_touch_calibrate_and_key_hit.sv -----
// tb_touch_calibrate_and_key_hit: self-checking bench for the touch calibration and key hit block.
// Needs tcak_pkg, tcak_in_if/tcak_out_if and touch_calibrate_and_key_hit; a directed table, then
// random phases under several register settings, checked against fixed rows or an in-bench predictor.

module tb_touch_calibrate_and_key_hit;
  import tcak_pkg::*;

  localparam int SCREEN_W        = DEF_SCREEN_WIDTH;
  localparam int SCREEN_H        = DEF_SCREEN_HEIGHT;
  localparam int KEYS            = DEF_KEY_COUNT;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DIRECTED_ROWS   = 25;

  // the one command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [SLOT_W-1:0]  key_slot;
    key_rect_t          rect;
  } touch_cmd_t;

  typedef struct packed {
    logic               pressed;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               key_hit;
    logic [IDX_W-1:0]   key_index;
  } touch_result_t;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic               cal_on;
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
  } cal_setting_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [SLOT_W-1:0]  key_slot;
    key_rect_t          rect;
    logic               typed;
    touch_result_t      want;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcak_in_if  in_if ();
  tcak_out_if out_if ();

  touch_calibrate_and_key_hit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  cal_setting_t       cfg_model = '0;
  logic [COORD_W-1:0] last_pos_x = '0;
  logic [COORD_W-1:0] last_pos_y = '0;
  key_rect_t          key_tab [KEYS];
  bit                 key_live [KEYS];

  touch_result_t pending_reports [$];

  bit steady_run = 1'b0;
  bit hold_req   = 1'b0;
  int mismatches = 0;
  int accepted_count = 0;
  int reports_checked = 0;
  int hits_seen = 0;
  int settings_applied = 0;

  // per phase: first_x, first_y, second_x, second_y, calibrated, origin_x, origin_y
  cal_setting_t phase_settings [5] = '{
    '{0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 20, 30},
    '{0, 0, 0, 0, 1, 0, 0},
    '{900, 100, 100, 900, 1, 0, 0},
    '{50, 1000, 1000, 50, 1, 1023, 1023}
  };

  // phase, command, raw x/y, slot, {left, top, width, height}, typed, {pressed, x, y, hit, index}
  directed_row_t directed_tab [DIRECTED_ROWS] = '{
    '{0, CMD_PEN_UP,   0,    0,    0,  '{0, 0, 0, 0},             1, '{0, 0, 0, 0, 0}},
    '{0, CMD_PEN_DOWN, 1023, 1023, 0,  '{0, 0, 0, 0},             1, '{1, 1023, 1023, 0, 0}},
    '{0, CMD_PEN_UP,   0,    0,    0,  '{0, 0, 0, 0},             1, '{0, 1023, 1023, 0, 0}},
    '{0, CMD_LOAD,     0,    0,    15, '{1023, 1023, 1023, 1023}, 0, '{0, 0, 0, 0, 0}},
    '{0, CMD_PEN_DOWN, 1023, 1023, 0,  '{0, 0, 0, 0},             1, '{1, 1023, 1023, 1, 15}},
    '{0, CMD_LOAD,     0,    0,    0,  '{0, 0, 0, 0},             0, '{0, 0, 0, 0, 0}},
    '{0, CMD_PEN_DOWN, 0,    0,    0,  '{0, 0, 0, 0},             1, '{1, 0, 0, 1, 0}},
    '{0, CMD_PEN_DOWN, 1,    0,    0,  '{0, 0, 0, 0},             1, '{1, 1, 0, 0, 0}},
    '{0, CMD_LOAD,     0,    0,    3,  '{10, 20, 5, 5},           0, '{0, 0, 0, 0, 0}},
    '{0, CMD_PEN_DOWN, 15,   25,   0,  '{0, 0, 0, 0},             1, '{1, 15, 25, 1, 3}},
    '{0, CMD_PEN_DOWN, 16,   25,   0,  '{0, 0, 0, 0},             1, '{1, 16, 25, 0, 0}},
    '{0, CMD_LOAD,     0,    0,    2,  '{0, 0, 1023, 1023},       0, '{0, 0, 0, 0, 0}},
    '{0, CMD_PEN_DOWN, 15,   25,   0,  '{0, 0, 0, 0},             1, '{1, 15, 25, 1, 2}},
    '{0, CMD_UNUSED,   682,  341,  10, '{341, 682, 341, 682},     0, '{0, 0, 0, 0, 0}},
    '{0, CMD_PEN_UP,   341,  682,  5,  '{682, 341, 682, 341},     1, '{0, 15, 25, 0, 0}},
    // point left of or above the origin never hits
    '{1, CMD_PEN_DOWN, 19,   40,   0,  '{0, 0, 0, 0},             1, '{1, 19, 40, 0, 0}},
    '{1, CMD_PEN_DOWN, 40,   29,   0,  '{0, 0, 0, 0},             1, '{1, 40, 29, 0, 0}},
    '{1, CMD_PEN_DOWN, 20,   30,   0,  '{0, 0, 0, 0},             1, '{1, 20, 30, 1, 0}},
    // calibration differences all zero: scaled terms drop out
    '{2, CMD_PEN_DOWN, 500,  600,  0,  '{0, 0, 0, 0},             1, '{1, 315, 5, 1, 2}},
    '{2, CMD_PEN_UP,   0,    0,    0,  '{0, 0, 0, 0},             1, '{0, 315, 5, 0, 0}},
    '{3, CMD_PEN_DOWN, 0,    0,    0,  '{0, 0, 0, 0},             0, '{0, 0, 0, 0, 0}},
    '{3, CMD_PEN_DOWN, 1023, 1023, 0,  '{0, 0, 0, 0},             0, '{0, 0, 0, 0, 0}},
    '{3, CMD_PEN_DOWN, 500,  500,  0,  '{0, 0, 0, 0},             0, '{0, 0, 0, 0, 0}},
    '{4, CMD_PEN_DOWN, 300,  700,  0,  '{0, 0, 0, 0},             0, '{0, 0, 0, 0, 0}},
    '{4, CMD_PEN_DOWN, 1023, 0,    0,  '{0, 0, 0, 0},             0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int scaled_term(input int num, input int span, input int den);
    if (den == 0) return 0;
    return (num * span) / den;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_screen(input int v, input int extent);
    if (v < 0) return '0;
    if (v >= extent) return COORD_W'(extent - 1);
    return COORD_W'(v);
  endfunction

  function automatic void store_register(input int idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CAL_FIRST_X:  cfg_model.first_x  = data;
      CFG_CAL_FIRST_Y:  cfg_model.first_y  = data;
      CFG_CAL_SECOND_X: cfg_model.second_x = data;
      CFG_CAL_SECOND_Y: cfg_model.second_y = data;
      CFG_CALIBRATED:   cfg_model.cal_on   = data[0];
      CFG_ORIGIN_X:     cfg_model.org_x    = data;
      CFG_ORIGIN_Y:     cfg_model.org_y    = data;
      default: ;
    endcase
  endfunction

  // updates the mirrored state; returns 1 when the command yields a report
  function automatic bit predict_touch(input touch_cmd_t c, output touch_result_t r);
    int tx;
    int ty;
    int dx;
    int dy;
    bit found;
    r = '0;
    found = 1'b0;
    case (c.command)
      CMD_LOAD: begin
        if (int'(c.key_slot) < KEYS) begin
          key_tab[c.key_slot] = c.rect;
          key_live[c.key_slot] = 1'b1;
        end
        return 1'b0;
      end
      CMD_PEN_UP: r.pressed = 1'b0;
      CMD_PEN_DOWN: begin
        if (cfg_model.cal_on) begin
          ty = scaled_term(int'(c.raw_y) - int'(cfg_model.first_y), SCREEN_H - CAL_MARGIN,
                           int'(cfg_model.second_y) - int'(cfg_model.first_y)) + CAL_OFFSET;
          tx = scaled_term(int'(c.raw_x) - int'(cfg_model.second_x), SCREEN_W - CAL_MARGIN,
                           int'(cfg_model.first_x) - int'(cfg_model.second_x)) + CAL_OFFSET;
          last_pos_x = clamp_screen(SCREEN_W - tx, SCREEN_W);
          last_pos_y = clamp_screen(ty, SCREEN_H);
        end else begin
          last_pos_x = c.raw_x;
          last_pos_y = c.raw_y;
        end
        dx = int'(last_pos_x) - int'(cfg_model.org_x);
        dy = int'(last_pos_y) - int'(cfg_model.org_y);
        if (dx >= 0 && dy >= 0) begin
          for (int i = 0; i < KEYS && !found; i++) begin
            if (key_live[i] && dx >= int'(key_tab[i].left) &&
                dx <= int'(key_tab[i].left) + int'(key_tab[i].width) &&
                dy >= int'(key_tab[i].top) &&
                dy <= int'(key_tab[i].top) + int'(key_tab[i].height)) begin
              found = 1'b1;
              r.key_index = IDX_W'(i);
            end
          end
        end
        r.pressed = 1'b1;
        r.key_hit = found;
      end
      default: return 1'b0;
    endcase
    r.pos_x = last_pos_x;
    r.pos_y = last_pos_y;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [CFG_DATA_W-1:0] reg_word(input cal_setting_t s, input int idx);
    logic [CFG_DATA_W-1:0] w;
    w = '0;
    case (idx)
      CFG_CAL_FIRST_X:  w = s.first_x;
      CFG_CAL_FIRST_Y:  w = s.first_y;
      CFG_CAL_SECOND_X: w = s.second_x;
      CFG_CAL_SECOND_Y: w = s.second_y;
      CFG_CALIBRATED: begin
        // only bit 0 counts, the rest is noise
        w = CFG_DATA_W'($urandom);
        w[0] = s.cal_on;
      end
      CFG_ORIGIN_X:     w = s.org_x;
      CFG_ORIGIN_Y:     w = s.org_y;
      default: ;
    endcase
    return w;
  endfunction

  function automatic cal_setting_t random_setting(input int p);
    cal_setting_t s;
    s.cal_on   = 1'b1;
    s.org_x    = $urandom_range(40);
    s.org_y    = $urandom_range(40);
    s.first_x  = $urandom_range(950, 850);
    s.first_y  = $urandom_range(150, 80);
    s.second_x = $urandom_range(150, 80);
    s.second_y = $urandom_range(950, 850);
    case (p)
      0: begin
        s.cal_on = 1'b0;
        s.org_x  = '0;
        s.org_y  = '0;
      end
      1: begin
        s.first_x  = 1023;
        s.first_y  = 0;
        s.second_x = 0;
        s.second_y = 1023;
      end
      2: begin
        // mirrored crosses: both divisors negative
        s.first_x  = 0;
        s.first_y  = 1023;
        s.second_x = 1023;
        s.second_y = 0;
      end
      6: begin
        s.first_x  = $urandom_range(1023);
        s.first_y  = $urandom_range(1023);
        s.second_x = $urandom_range(1023);
        s.second_y = $urandom_range(1023);
        if ($urandom_range(1) == 0) s.second_y = s.first_y;
        else s.second_x = s.first_x;
      end
      7: begin
        s.cal_on = 1'b0;
        s.org_x  = $urandom_range(1023);
        s.org_y  = $urandom_range(1023);
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic touch_cmd_t random_cmd(input cal_setting_t s);
    touch_cmd_t c;
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) c.command = CMD_PEN_DOWN;
    else if (roll < 70) c.command = CMD_PEN_UP;
    else if (roll < 95) c.command = CMD_LOAD;
    else c.command = CMD_UNUSED;
    c.raw_x = $urandom_range(1023);
    c.raw_y = $urandom_range(1023);
    // most samples land between the crosses, or on screen when uncalibrated
    if ($urandom_range(9) < 8) begin
      if (s.cal_on) begin
        c.raw_x = $urandom_range(s.first_x, s.second_x);
        c.raw_y = $urandom_range(s.first_y, s.second_y);
      end else begin
        c.raw_x = $urandom_range(SCREEN_W - 1);
        c.raw_y = $urandom_range(SCREEN_H - 1);
      end
    end
    c.key_slot = $urandom_range(KEYS - 1);
    if ($urandom_range(99) < 85) begin
      c.rect.left   = $urandom_range(SCREEN_W - 1);
      c.rect.top    = $urandom_range(SCREEN_H - 1);
      c.rect.width  = $urandom_range(60);
      c.rect.height = $urandom_range(60);
    end else begin
      c.rect.left   = $urandom_range(1023);
      c.rect.top    = $urandom_range(1023);
      c.rect.width  = $urandom_range(1023);
      c.rect.height = $urandom_range(1023);
    end
    return c;
  endfunction

  task automatic offer_item(input touch_cmd_t c, input bit typed, input touch_result_t fixed);
    touch_result_t r;
    if (!steady_run && $urandom_range(99) < 28) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= c.command;
    in_if.raw_x      <= c.raw_x;
    in_if.raw_y      <= c.raw_y;
    in_if.key_slot   <= c.key_slot;
    in_if.key_left   <= c.rect.left;
    in_if.key_top    <= c.rect.top;
    in_if.key_width  <= c.rect.width;
    in_if.key_height <= c.rect.height;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    accepted_count++;
    if (predict_touch(c, r)) pending_reports.push_back(typed ? fixed : r);
  endtask

  // loads and unused commands give no report, so allow the block to finish after the last one
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input cal_setting_t s);
    logic [CFG_DATA_W-1:0] w;
    wait_idle();
    for (int idx = CFG_CAL_FIRST_X; idx <= CFG_ORIGIN_Y; idx++) begin
      w = reg_word(s, idx);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(idx);
      cfg_data  <= w;
      store_register(idx, w);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------- result side

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : report_sink
    int hold_left;
    touch_result_t want;
    hold_left = 0;
    forever begin
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        // long back-pressure so the block fills and stalls its input
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady_run || ($urandom_range(99) >= 28);
      end
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual pressed=%0d x=%0d y=%0d hit=%0d index=%0d",
                   $time, out_if.pressed, out_if.pos_x, out_if.pos_y, out_if.key_hit,
                   out_if.key_index);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("pressed", want.pressed, out_if.pressed);
          check_field("pos_x", want.pos_x, out_if.pos_x);
          check_field("pos_y", want.pos_y, out_if.pos_y);
          check_field("key_hit", want.key_hit, out_if.key_hit);
          check_field("key_index", want.key_index, out_if.key_index);
          reports_checked++;
          if (want.key_hit) hits_seen++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d reports outstanding", $time, cycles,
             pending_reports.size());
    $display("FAIL touch_calibrate_and_key_hit");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    touch_cmd_t c;
    cal_setting_t s;
    int cur_phase;
    int counted;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_CAL_FIRST_X;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_PEN_DOWN;
    in_if.raw_x      <= '0;
    in_if.raw_y      <= '0;
    in_if.key_slot   <= '0;
    in_if.key_left   <= '0;
    in_if.key_top    <= '0;
    in_if.key_width  <= '0;
    in_if.key_height <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    cur_phase = 0;
    foreach (directed_tab[i]) begin
      if (int'(directed_tab[i].phase) != cur_phase) begin
        cur_phase = directed_tab[i].phase;
        apply_setting(phase_settings[cur_phase]);
      end
      c.command  = directed_tab[i].command;
      c.raw_x    = directed_tab[i].raw_x;
      c.raw_y    = directed_tab[i].raw_y;
      c.key_slot = directed_tab[i].key_slot;
      c.rect     = directed_tab[i].rect;
      offer_item(c, directed_tab[i].typed, directed_tab[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      s = random_setting(p);
      apply_setting(s);
      steady_run = (p == 3);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (p == 5 && counted == 20) hold_req = 1'b1;
        c = random_cmd(s);
        offer_item(c, 1'b0, '0);
        if (c.command != CMD_UNUSED) counted++;
      end
      steady_run = 1'b0;
    end

    wait_idle();
    $display("covered %0d accepted transactions over %0d register settings",
             accepted_count, settings_applied);
    $display("%0d reports checked, %0d with a key hit, %0d mismatches",
             reports_checked, hits_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS touch_calibrate_and_key_hit");
    end else begin
      $display("FAIL touch_calibrate_and_key_hit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tcak_pkg.sv
hdl/tcak_if.sv
hdl/tcak_scale.sv
hdl/tcak_keys.sv
hdl/touch_calibrate_and_key_hit.sv
tb/sv/tb_touch_calibrate_and_key_hit.sv
